### rtl/utf_pkg.sv
// Shared types and constants for the UTF-16/UTF-32 to UTF-8 transcoder.
// Used by every module under rtl; depends on nothing else.
package utf_pkg;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0] REG_ENCODING_MODE = 1'b0;
   localparam int MODE_W = 3;

   // Source encodings
   localparam logic [MODE_W-1:0] MODE_UTF8    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_UTF16LE = 3'd1;
   localparam logic [MODE_W-1:0] MODE_UTF16BE = 3'd2;
   localparam logic [MODE_W-1:0] MODE_UTF32LE = 3'd3;
   localparam logic [MODE_W-1:0] MODE_UTF32BE = 3'd4;
   localparam logic [MODE_W-1:0] MODE_RAW     = 3'd5;

   // Byte order mark and encoding limits
   localparam logic [7:0]  BOM_BYTE0  = 8'hef;
   localparam logic [7:0]  BOM_BYTE1  = 8'hbb;
   localparam logic [7:0]  BOM_BYTE2  = 8'hbf;
   localparam logic [31:0] UNIT_BOM   = 32'h0000_feff;
   localparam logic [31:0] LIMIT_1B   = 32'h0000_0080;
   localparam logic [31:0] LIMIT_2B   = 32'h0000_0800;
   localparam logic [31:0] LIMIT_3B   = 32'h0001_0000;
   localparam logic [31:0] LIMIT_4B   = 32'h0011_0000;
   localparam logic [7:0]  LEAD_2B    = 8'hc0;
   localparam logic [7:0]  LEAD_3B    = 8'he0;
   localparam logic [7:0]  LEAD_4B    = 8'hf0;
   localparam logic [7:0]  CONT_MARK  = 8'h80;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   typedef enum logic {
      JOB_BYTES = 1'b0,
      JOB_UNIT  = 1'b1
   } job_kind_type;

   // One queued piece of work: up to three literal bytes or one code point.
   typedef struct packed {
      job_kind_type kind;
      logic [23:0]  data;
      logic [1:0]   last_idx;
      logic         eot;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

### rtl/utf_front.sv
// Front end: accepts source bytes, gathers code units, strips byte order marks
// and hands finished jobs to the queue. Depends on utf_pkg.
module utf_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           cfg_restart,
   input  logic [utf_pkg::MODE_W-1:0]     mode,
   input  logic                           accept,
   input  logic [7:0]                     in_byte,
   input  logic                           in_eot,
   output logic                           job_push,
   output utf_pkg::job_type               job
);
   import utf_pkg::*;

   logic [23:0] held_ff, held_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        first_ff, first_in;

   logic [23:0] hold_data;
   logic [7:0]  bom_expect;
   logic [31:0] cp;
   logic        unit;
   logic        drop;

   assign hold_data = held_ff | (24'(in_byte) << {cnt_ff, 3'b000});

   always_comb begin
      case (cnt_ff)
         2'd0: begin
            bom_expect = BOM_BYTE0;
         end
         2'd1: begin
            bom_expect = BOM_BYTE1;
         end
         default: begin
            bom_expect = BOM_BYTE2;
         end
      endcase
   end

   always_comb begin
      held_in  = held_ff;
      cnt_in   = cnt_ff;
      first_in = first_ff;
      job_push = 1'b0;
      job      = '{kind: JOB_BYTES, data: 24'(in_byte), last_idx: 2'd0, eot: in_eot};
      cp       = '0;
      unit     = 1'b0;
      drop     = 1'b0;

      case (mode)
         MODE_UTF8: begin
            if (!first_ff) begin
               job_push = 1'b1;
            end else if (in_byte == bom_expect) begin
               if (cnt_ff == 2'd2) begin
                  first_in = 1'b0;
                  held_in  = '0;
                  cnt_in   = '0;
               end else begin
                  held_in = hold_data;
                  cnt_in  = cnt_ff + 2'd1;
                  // A partial mark at the end of the text is passed on as is.
                  if (in_eot) begin
                     job_push     = 1'b1;
                     job.data     = hold_data;
                     job.last_idx = cnt_ff;
                  end
               end
            end else begin
               job_push     = 1'b1;
               job.data     = hold_data;
               job.last_idx = cnt_ff;
               first_in     = 1'b0;
               held_in      = '0;
               cnt_in       = '0;
            end
         end
         MODE_UTF16LE, MODE_UTF16BE: begin
            if (cnt_ff == 2'd0) begin
               held_in = hold_data;
               cnt_in  = cnt_ff + 2'd1;
            end else begin
               unit = 1'b1;
               cp   = (mode == MODE_UTF16LE) ? {16'd0, in_byte, held_ff[7:0]}
                                             : {16'd0, held_ff[7:0], in_byte};
            end
         end
         MODE_UTF32LE, MODE_UTF32BE: begin
            if (cnt_ff != 2'd3) begin
               held_in = hold_data;
               cnt_in  = cnt_ff + 2'd1;
            end else begin
               unit = 1'b1;
               cp   = (mode == MODE_UTF32LE)
                    ? {in_byte, held_ff[23:16], held_ff[15:8], held_ff[7:0]}
                    : {held_ff[7:0], held_ff[15:8], held_ff[23:16], in_byte};
            end
         end
         default: begin
            job_push = 1'b1;
         end
      endcase

      if (unit) begin
         drop     = first_ff && (cp == UNIT_BOM);
         first_in = 1'b0;
         held_in  = '0;
         cnt_in   = '0;
         if (!drop && (cp < LIMIT_4B)) begin
            job_push = 1'b1;
            job.kind = JOB_UNIT;
            job.data = cp[23:0];
            if (cp < LIMIT_1B) begin
               job.last_idx = 2'd0;
            end else if (cp < LIMIT_2B) begin
               job.last_idx = 2'd1;
            end else if (cp < LIMIT_3B) begin
               job.last_idx = 2'd2;
            end else begin
               job.last_idx = 2'd3;
            end
         end
      end

      if (in_eot) begin
         held_in  = '0;
         cnt_in   = '0;
         first_in = 1'b1;
      end

      job_push = job_push && accept;
   end

   always_ff @(posedge clock) begin
      if (reset || cfg_restart) begin
         held_ff  <= '0;
         cnt_ff   <= '0;
         first_ff <= 1'b1;
      end else if (accept) begin
         held_ff  <= held_in;
         cnt_ff   <= cnt_in;
         first_ff <= first_in;
      end
   end

endmodule

### rtl/utf_queue.sv
// Short job queue between the front end and the byte serializer.
// Depends on utf_pkg for the job type.
module utf_queue #(
   parameter int DEPTH = utf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  utf_pkg::job_type           push_job,
   input  logic                       pop,
   output utf_pkg::job_type           head,
   output utf_pkg::queue_status_type  status
);
   import utf_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   job_type         mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign status.full  = (count_ff == CW'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### rtl/utf_back.sv
// Back end: turns the job at the queue head into UTF-8 bytes, one per cycle while
// the output is not stalled, into a registered result stage. Depends on utf_pkg.
module utf_back (
   input  logic                       clock,
   input  logic                       reset,
   input  utf_pkg::job_type           head,
   input  logic                       head_valid,
   output logic                       head_pop,
   input  logic                       rsp_take,
   output logic                       rsp_valid,
   output logic [7:0]                 rsp_byte,
   output logic                       rsp_last,
   output logic                       rsp_eot
);
   import utf_pkg::*;

   logic [1:0]  idx_ff;
   logic        out_valid_ff;
   logic [7:0]  out_byte_ff;
   logic        out_last_ff;
   logic        out_eot_ff;

   logic        out_free;
   logic        advance;
   logic        at_last;
   logic [1:0]  grp_left;
   logic [4:0]  shamt;
   logic [5:0]  seg;
   logic [7:0]  lead;
   logic [7:0]  next_byte;

   assign out_free = !out_valid_ff || rsp_take;
   assign advance  = out_free && head_valid;
   assign at_last  = (idx_ff == head.last_idx);
   assign head_pop = advance && at_last;

   // Continuation bytes take six code point bits each, highest group first.
   assign grp_left = head.last_idx - idx_ff;
   assign shamt    = 5'(grp_left) * 5'd6;
   assign seg      = 6'(head.data[20:0] >> shamt);

   always_comb begin
      case (head.last_idx)
         2'd0: begin
            lead = {1'b0, head.data[6:0]};
         end
         2'd1: begin
            lead = LEAD_2B | {3'b000, head.data[10:6]};
         end
         2'd2: begin
            lead = LEAD_3B | {4'h0, head.data[15:12]};
         end
         default: begin
            lead = LEAD_4B | {5'h00, head.data[20:18]};
         end
      endcase
   end

   always_comb begin
      if (head.kind == JOB_BYTES) begin
         next_byte = head.data[{idx_ff, 3'b000} +: 8];
      end else if (idx_ff == 2'd0) begin
         next_byte = lead;
      end else begin
         next_byte = CONT_MARK | {2'b00, seg};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
         idx_ff       <= at_last ? 2'd0 : idx_ff + 2'd1;
      end else if (rsp_take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_byte_ff <= next_byte;
         out_last_ff <= at_last;
         out_eot_ff  <= head.eot;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_byte  = out_byte_ff;
   assign rsp_last  = out_last_ff;
   assign rsp_eot   = out_eot_ff;

endmodule

### rtl/utf16_utf32_to_utf8_transcoder.sv
// Top level of the UTF-16/UTF-32 to UTF-8 transcoder: register port, front end,
// job queue and byte serializer. Depends on utf_pkg, utf_front, utf_queue, utf_back.
//
//   Channel   Ports                                         Transaction when
//   input     push, full, req_in_byte, req_end_of_text      push && !full
//   result    empty, pop, rsp_out_byte, rsp_last_of_run,    pop && !empty
//             rsp_ends_text
//   config    psel, penable, pwrite, paddr, pwdata,         psel && penable && pwrite
//             prdata, pready
//
// An input byte is taken every cycle while the job queue has room; the result
// side delivers one byte per cycle while it is popped, so a code unit that expands
// to N bytes occupies the serializer for its whole run and sets the sustained rate.
// The first byte of a job is written into the job queue and then into the result
// register before it is on the result ports.
// Reset is synchronous and selects UTF-8 mode with an empty pipeline.
// Either side may stall; the queue and the result register absorb the slack.
module utf16_utf32_to_utf8_transcoder #(
   parameter int QUEUE_DEPTH = utf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   output logic                              full,
   input  logic [7:0]                        req_in_byte,
   input  logic                              req_end_of_text,
   output logic                              empty,
   input  logic                              pop,
   output logic [7:0]                        rsp_out_byte,
   output logic                              rsp_last_of_run,
   output logic                              rsp_ends_text,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [utf_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [utf_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [utf_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);
   import utf_pkg::*;

   logic [MODE_W-1:0] mode_ff, mode_in;
   logic              csr_write;
   logic              csr_hit;
   logic              accept;
   logic              job_push;
   job_type           job;
   job_type           head;
   queue_status_type  q_status;
   logic              head_pop;
   logic              rsp_valid;

   assign pready    = 1'b1;
   assign csr_hit   = (paddr[CSR_ADDR_W-1:2] == REG_ENCODING_MODE);
   assign csr_write = psel && penable && pwrite && csr_hit;
   assign mode_in   = csr_write ? pwdata[MODE_W-1:0] : mode_ff;
   assign prdata    = csr_hit ? CSR_DATA_W'(mode_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_UTF8;
      end else begin
         mode_ff <= mode_in;
      end
   end

   assign full   = q_status.full;
   assign accept = push && !full;

   utf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg_restart (csr_write),
      .mode        (mode_ff),
      .accept      (accept),
      .in_byte     (req_in_byte),
      .in_eot      (req_end_of_text),
      .job_push    (job_push),
      .job         (job)
   );

   utf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (job),
      .pop      (head_pop),
      .head     (head),
      .status   (q_status)
   );

   utf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (!q_status.empty),
      .head_pop   (head_pop),
      .rsp_take   (pop && rsp_valid),
      .rsp_valid  (rsp_valid),
      .rsp_byte   (rsp_out_byte),
      .rsp_last   (rsp_last_of_run),
      .rsp_eot    (rsp_ends_text)
   );

   assign empty = !rsp_valid;

`ifndef ASSERT_OFF
   // The rest of a multi-byte run is already queued, so the next byte follows at once.
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (!empty && pop && !rsp_last_of_run) |=> !empty)
      else $error("result run broken before its last byte");

   // All bytes of one run come from the same input transaction.
   a_run_eot_stable: assert property (@(posedge clock) disable iff (reset)
      (!empty && pop && !rsp_last_of_run) |=> (rsp_ends_text == $past(rsp_ends_text)))
      else $error("end-of-text flag changed within a run");

   // A job is only removed from the queue when the queue holds one, as its last byte enters the result register.
   a_pop_needs_job: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> !q_status.empty)
      else $error("queue popped while empty");
`endif

endmodule

### sim/utf8_stream_checker.sv
`timescale 1ns / 100ps
// Checker for the UTF-16/UTF-32 to UTF-8 transcoder: it watches the input, result and
// register channels, predicts the output bytes and compares them. Depends on utf_pkg.
module utf8_stream_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  logic                           full,
   input  logic [7:0]                     req_in_byte,
   input  logic                           req_end_of_text,
   input  logic                           empty,
   input  logic                           pop,
   input  logic [7:0]                     rsp_out_byte,
   input  logic                           rsp_last_of_run,
   input  logic                           rsp_ends_text,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [utf_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [utf_pkg::CSR_DATA_W-1:0] pwdata,
   input  logic [utf_pkg::CSR_DATA_W-1:0] prdata,
   input  logic                           pready,
   output int                             mismatch_count,
   output int                             pending_bytes
);
   import utf_pkg::*;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       ends_text;
   } utf8_byte_type;

   // Predicted stream state.
   logic [MODE_W-1:0] mode_now;
   logic [23:0]       unit_bytes;
   logic [1:0]        unit_fill;
   logic              stream_fresh;

   logic [7:0]    run_q[$];
   utf8_byte_type expected_bytes_q[$];

   initial mismatch_count = 0;

   task automatic report_error(input string what);
      $display("%0t ERROR: %s", $time, what);
      mismatch_count++;
   endtask

   function automatic void clear_unit(input logic fresh);
      unit_bytes   = '0;
      unit_fill    = '0;
      stream_fresh = fresh;
   endfunction

   function automatic void hold_byte(input logic [7:0] b);
      unit_bytes[8*unit_fill +: 8] = b;
      unit_fill = unit_fill + 2'd1;
   endfunction

   function automatic void encode_code_point(input logic [31:0] cp);
      if (cp < LIMIT_1B) begin
         run_q.push_back(cp[7:0]);
      end else if (cp < LIMIT_2B) begin
         run_q.push_back(LEAD_2B | {3'b0, cp[10:6]});
         run_q.push_back(CONT_MARK | {2'b0, cp[5:0]});
      end else if (cp < LIMIT_3B) begin
         run_q.push_back(LEAD_3B | {4'b0, cp[15:12]});
         run_q.push_back(CONT_MARK | {2'b0, cp[11:6]});
         run_q.push_back(CONT_MARK | {2'b0, cp[5:0]});
      end else if (cp < LIMIT_4B) begin
         run_q.push_back(LEAD_4B | {5'b0, cp[20:18]});
         run_q.push_back(CONT_MARK | {2'b0, cp[17:12]});
         run_q.push_back(CONT_MARK | {2'b0, cp[11:6]});
         run_q.push_back(CONT_MARK | {2'b0, cp[5:0]});
      end
   endfunction

   // A byte order mark is only dropped when it is the first unit of the text.
   function automatic void accept_unit(input logic [31:0] cp);
      logic drop;
      drop = stream_fresh && (cp == UNIT_BOM);
      clear_unit(1'b0);
      if (!drop) encode_code_point(cp);
   endfunction

   task automatic predict_transaction(input logic [7:0] b, input logic eot);
      logic [1:0]  prefix_len;
      logic [7:0]  bom_next;
      logic [31:0] cp;
      int          i;
      run_q.delete();
      case (mode_now)
         MODE_UTF8: begin
            if (!stream_fresh) begin
               run_q.push_back(b);
            end else begin
               prefix_len = (unit_fill > 2'd2) ? 2'd2 : unit_fill;
               case (prefix_len)
                  2'd0: bom_next = BOM_BYTE0;
                  2'd1: bom_next = BOM_BYTE1;
                  default: bom_next = BOM_BYTE2;
               endcase
               if (b == bom_next) begin
                  if (prefix_len == 2'd2) begin
                     clear_unit(1'b0);
                  end else begin
                     hold_byte(b);
                     // A prefix cut short by the end of text comes out as plain bytes.
                     if (eot) begin
                        for (i = 0; i < unit_fill; i++) run_q.push_back(unit_bytes[8*i +: 8]);
                     end
                  end
               end else begin
                  for (i = 0; i < prefix_len; i++) run_q.push_back(unit_bytes[8*i +: 8]);
                  run_q.push_back(b);
                  clear_unit(1'b0);
               end
            end
         end
         MODE_UTF16LE, MODE_UTF16BE: begin
            if (unit_fill == 2'd0) begin
               hold_byte(b);
            end else begin
               cp = (mode_now == MODE_UTF16LE) ? {16'h0, b, unit_bytes[7:0]}
                                               : {16'h0, unit_bytes[7:0], b};
               accept_unit(cp);
            end
         end
         MODE_UTF32LE, MODE_UTF32BE: begin
            if (unit_fill < 2'd3) begin
               hold_byte(b);
            end else begin
               cp = (mode_now == MODE_UTF32LE) ? {b, unit_bytes[23:0]}
                  : {unit_bytes[7:0], unit_bytes[15:8], unit_bytes[23:16], b};
               accept_unit(cp);
            end
         end
         default: begin
            run_q.push_back(b);
         end
      endcase
      if (eot) clear_unit(1'b1);
      for (i = 0; i < run_q.size(); i++) begin
         expected_bytes_q.push_back('{out_byte: run_q[i],
                                      last_of_run: (i == run_q.size() - 1),
                                      ends_text: eot});
      end
   endtask

   task automatic check_result();
      utf8_byte_type want;
      if (expected_bytes_q.size() == 0) begin
         report_error($sformatf("unexpected result byte %h", rsp_out_byte));
      end else begin
         want = expected_bytes_q.pop_front();
         if (rsp_out_byte !== want.out_byte)
            report_error($sformatf("out_byte %h, expected %h", rsp_out_byte, want.out_byte));
         if (rsp_last_of_run !== want.last_of_run)
            report_error($sformatf("last_of_run %b, expected %b on byte %h",
                                   rsp_last_of_run, want.last_of_run, want.out_byte));
         if (rsp_ends_text !== want.ends_text)
            report_error($sformatf("ends_text %b, expected %b on byte %h",
                                   rsp_ends_text, want.ends_text, want.out_byte));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         mode_now = MODE_UTF8;
         clear_unit(1'b1);
         expected_bytes_q.delete();
      end else begin
         if (pop && !empty) check_result();
         if (psel && penable && pready && paddr[CSR_ADDR_W-1:2] == REG_ENCODING_MODE) begin
            if (pwrite) begin
               mode_now = pwdata[MODE_W-1:0];
               clear_unit(1'b1);
            end else if (prdata !== {{(CSR_DATA_W-MODE_W){1'b0}}, mode_now}) begin
               report_error($sformatf("encoding_mode read %h, expected %h", prdata, mode_now));
            end
         end
         if (push && !full) predict_transaction(req_in_byte, req_end_of_text);
      end
      pending_bytes <= expected_bytes_q.size();
   end

endmodule

### sim/utf16_utf32_to_utf8_transcoder_test.sv
`timescale 1ns / 100ps
// Top of the transcoder testbench: clock, reset, stimulus on the input, result and
// register channels, and the verdict. Depends on utf_pkg, utf8_stream_checker and the RTL.
module utf16_utf32_to_utf8_transcoder_test;
   import utf_pkg::*;

   localparam int RANDOM_ITEMS = 460;
   localparam int DRAIN_TAIL   = 8;
   localparam int LONG_HOLD    = 400;

   logic                  clock;
   logic                  reset           = 1'b1;
   logic                  push            = 1'b0;
   logic [7:0]            req_in_byte     = '0;
   logic                  req_end_of_text = 1'b0;
   logic                  pop             = 1'b0;
   logic                  psel            = 1'b0;
   logic                  penable         = 1'b0;
   logic                  pwrite          = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr           = '0;
   logic [CSR_DATA_W-1:0] pwdata          = '0;
   wire                   full, empty, rsp_last_of_run, rsp_ends_text, pready;
   wire  [7:0]            rsp_out_byte;
   wire  [CSR_DATA_W-1:0] prdata;

   int   mismatch_count;
   int   pending_bytes;
   int   burst_left   = 0;
   int   random_sent  = 0;
   bit   hold_request = 1'b0;
   logic [7:0] text_q[$];

   utf16_utf32_to_utf8_transcoder dut (
      .clock(clock), .reset(reset),
      .push(push), .full(full), .req_in_byte(req_in_byte),
      .req_end_of_text(req_end_of_text),
      .empty(empty), .pop(pop), .rsp_out_byte(rsp_out_byte),
      .rsp_last_of_run(rsp_last_of_run), .rsp_ends_text(rsp_ends_text),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   utf8_stream_checker utf8_check (
      .clock(clock), .reset(reset),
      .push(push), .full(full), .req_in_byte(req_in_byte),
      .req_end_of_text(req_end_of_text),
      .empty(empty), .pop(pop), .rsp_out_byte(rsp_out_byte),
      .rsp_last_of_run(rsp_last_of_run), .rsp_ends_text(rsp_ends_text),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready),
      .mismatch_count(mismatch_count), .pending_bytes(pending_bytes)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("Mismatches found");
      $finish;
   end

   // Result side: epochs of random stall density, plus one long hold-off on request.
   initial begin
      int epoch_left, stall_pct, hold_left;
      epoch_left = 0;
      stall_pct  = 0;
      hold_left  = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD;
            pop <= 1'b0;
         end else begin
            if (epoch_left == 0) begin
               epoch_left = $urandom_range(20, 100);
               case ($urandom_range(0, 3))
                  0: stall_pct = 0;
                  1: stall_pct = 20;
                  2: stall_pct = 50;
                  default: stall_pct = 85;
               endcase
            end
            epoch_left--;
            pop <= ($urandom_range(1, 100) > stall_pct);
         end
      end
   end

   task automatic push_byte(input logic [7:0] b, input logic eot);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      push <= 1'b1;
      req_in_byte <= b;
      req_end_of_text <= eot;
      do @(posedge clock); while (full);
      burst_left--;
   endtask

   // Stop sending and wait until every predicted byte has come out.
   task automatic drain();
      push <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_bytes != 0) @(posedge clock);
      repeat (DRAIN_TAIL) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= addr;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_mode(input logic [MODE_W-1:0] m);
      logic [CSR_DATA_W-1:0] value;
      value = $urandom;
      value[MODE_W-1:0] = m;
      csr_access(1'b1, {REG_ENCODING_MODE, 2'b00}, value);
      csr_access(1'b0, {REG_ENCODING_MODE, 2'b00}, '0);
   endtask

   function automatic logic [31:0] random_code_point(input logic narrow);
      int pick;
      logic [31:0] cp;
      pick = $urandom_range(0, 99);
      if (pick < 25)      cp = $urandom_range(0, 'h7f);
      else if (pick < 45) cp = $urandom_range('h80, 'h7ff);
      else if (pick < 60) cp = $urandom_range('h800, 'hffff);
      else if (pick < 68) cp = $urandom_range('hd800, 'hdfff);
      else if (pick < 80) cp = $urandom_range('h10000, 'h10ffff);
      else if (pick < 85) cp = UNIT_BOM;
      else if (pick < 93) cp = $urandom_range(32'hffff_ffff, LIMIT_4B);
      else begin
         case ($urandom_range(0, 7))
            0: cp = 32'h0;
            1: cp = LIMIT_1B - 1;
            2: cp = LIMIT_1B;
            3: cp = LIMIT_2B - 1;
            4: cp = LIMIT_2B;
            5: cp = LIMIT_3B - 1;
            6: cp = LIMIT_4B - 1;
            default: cp = 32'hffff_ffff;
         endcase
      end
      if (narrow) cp = {16'h0, cp[15:0]};
      return cp;
   endfunction

   function automatic void add_unit(input logic [MODE_W-1:0] m, input logic [31:0] cp);
      case (m)
         MODE_UTF16LE: begin
            text_q.push_back(cp[7:0]);
            text_q.push_back(cp[15:8]);
         end
         MODE_UTF16BE: begin
            text_q.push_back(cp[15:8]);
            text_q.push_back(cp[7:0]);
         end
         MODE_UTF32LE: begin
            text_q.push_back(cp[7:0]);
            text_q.push_back(cp[15:8]);
            text_q.push_back(cp[23:16]);
            text_q.push_back(cp[31:24]);
         end
         default: begin
            text_q.push_back(cp[31:24]);
            text_q.push_back(cp[23:16]);
            text_q.push_back(cp[15:8]);
            text_q.push_back(cp[7:0]);
         end
      endcase
   endfunction

   // Random code units, surrogates and too-large values among them, sometimes led by
   // a byte order mark and sometimes followed by a partial unit.
   task automatic build_unit_text(input logic [MODE_W-1:0] m);
      logic narrow;
      int   unit_len;
      narrow = (m == MODE_UTF16LE) || (m == MODE_UTF16BE);
      unit_len = narrow ? 2 : 4;
      text_q.delete();
      if ($urandom_range(0, 1) == 0) add_unit(m, UNIT_BOM);
      repeat ($urandom_range(1, 8)) add_unit(m, random_code_point(narrow));
      if ($urandom_range(0, 5) == 0) begin
         repeat ($urandom_range(1, unit_len - 1)) text_q.push_back(8'($urandom));
      end
   endtask

   task automatic build_utf8_text();
      text_q.delete();
      case ($urandom_range(0, 5))
         0, 1: begin
            text_q.push_back(BOM_BYTE0);
            text_q.push_back(BOM_BYTE1);
            text_q.push_back(BOM_BYTE2);
         end
         2: text_q.push_back(BOM_BYTE0);
         3: begin
            text_q.push_back(BOM_BYTE0);
            text_q.push_back(BOM_BYTE1);
         end
         default: ;
      endcase
      repeat ($urandom_range(0, 10)) begin
         case ($urandom_range(0, 7))
            0: text_q.push_back(BOM_BYTE0);
            1: text_q.push_back(BOM_BYTE1);
            2: text_q.push_back(BOM_BYTE2);
            default: text_q.push_back(8'($urandom));
         endcase
      end
      if (text_q.size() == 0) text_q.push_back(8'($urandom));
   endtask

   task automatic build_noise();
      text_q.delete();
      repeat ($urandom_range(1, 12)) text_q.push_back(8'($urandom));
   endtask

   task automatic send_text(input logic eot_at_end);
      int i;
      for (i = 0; i < text_q.size(); i++) begin
         push_byte(text_q[i], eot_at_end && (i == text_q.size() - 1));
         random_sent++;
      end
   endtask

   initial begin
      int phase, phase_target, pick;
      logic [MODE_W-1:0] m;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // UTF-8 mode out of reset: stripped mark, partial mark at the end of text,
      // and a complete mark as the final item.
      push_byte(BOM_BYTE0, 1'b0);
      push_byte(BOM_BYTE1, 1'b0);
      push_byte(BOM_BYTE2, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'hff, 1'b1);
      push_byte(BOM_BYTE0, 1'b0);
      push_byte(BOM_BYTE1, 1'b1);
      push_byte(BOM_BYTE0, 1'b0);
      push_byte(BOM_BYTE1, 1'b0);
      push_byte(BOM_BYTE2, 1'b1);
      drain();

      // A dropped leading mark, a lone surrogate, then one byte left pending
      // that the following register write must discard.
      set_mode(MODE_UTF16BE);
      push_byte(8'hfe, 1'b0);
      push_byte(8'hff, 1'b0);
      push_byte(8'hd8, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h12, 1'b0);
      drain();

      // Out-of-range unit, the largest valid unit, then an incomplete trailing unit.
      set_mode(MODE_UTF32BE);
      push_byte(8'h00, 1'b0);
      push_byte(8'h11, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h10, 1'b0);
      push_byte(8'hff, 1'b0);
      push_byte(8'hff, 1'b1);
      push_byte(8'h00, 1'b0);
      push_byte(8'h00, 1'b1);
      drain();

      // Mode seven copies bytes; a write past the register list changes nothing.
      set_mode(3'd7);
      push_byte(8'h80, 1'b1);
      drain();
      csr_access(1'b1, {~REG_ENCODING_MODE, 2'b00}, {{(CSR_DATA_W-MODE_W){1'b0}}, MODE_UTF8});
      push_byte(8'hef, 1'b1);
      drain();

      random_sent = 0;
      phase = 0;
      while (random_sent < RANDOM_ITEMS) begin
         m = (phase < 8) ? phase[MODE_W-1:0] : MODE_W'($urandom_range(0, 7));
         set_mode(m);
         // One phase runs against a stalled result side so the input backs up.
         if (phase == 3) hold_request = 1'b1;
         phase_target = random_sent + $urandom_range(25, 50);
         if (phase_target > RANDOM_ITEMS) phase_target = RANDOM_ITEMS;
         while (random_sent < phase_target) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) build_noise();
            else if (m inside {MODE_UTF16LE, MODE_UTF16BE, MODE_UTF32LE, MODE_UTF32BE})
               build_unit_text(m);
            else if (m == MODE_UTF8) build_utf8_text();
            else build_noise();
            send_text($urandom_range(0, 9) != 0);
         end
         drain();
         phase++;
      end

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
